// ===== rtl/lbrs_pkg.sv =====
package lbrs_pkg;

   localparam int unsigned PwmWidth   = 10;
   localparam int unsigned FetWidth   = 8;
   localparam int unsigned LevelWidth = 8;
   localparam int unsigned FetShift   = 2;

   typedef enum logic [1:0] {
      CMD_WRITE_ENTRY = 2'd0,
      CMD_SET_LEVEL   = 2'd1,
      CMD_TICK        = 2'd2,
      CMD_NONE        = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      TBL_MAIN   = 2'd0,
      TBL_FET    = 2'd1,
      TBL_SECOND = 2'd2,
      TBL_NONE   = 2'd3
   } table_sel_type;

   typedef enum logic [1:0] {
      REG_CHANNEL_SELECT = 2'd0,
      REG_FET_PRESENT    = 2'd1,
      REG_PWM_TOP        = 2'd2,
      REG_UNUSED         = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [1:0]            cmd;
      logic [1:0]            table_select;
      logic [7:0]            entry_index;
      logic [PwmWidth-1:0]   entry_value;
      logic [LevelWidth-1:0] level_value;
   } req_type;

   typedef struct packed {
      logic [PwmWidth-1:0]   main_pwm;
      logic [FetWidth-1:0]   fet_pwm;
      logic [PwmWidth-1:0]   second_pwm;
      logic                  main_enable;
      logic                  second_enable;
      logic [LevelWidth-1:0] current_level;
   } rsp_type;

   function automatic logic [PwmWidth-1:0] step_toward(input logic [PwmWidth-1:0] cur,
                                                       input logic [PwmWidth-1:0] goal);
      logic [PwmWidth-1:0] result;
      if (cur < goal) begin
         result = cur + 1'b1;
      end else if (cur > goal) begin
         result = cur - 1'b1;
      end else begin
         result = cur;
      end
      return result;
   endfunction

endpackage

// ===== rtl/lbrs_ram.sv =====
module lbrs_ram #(
   parameter int unsigned WIDTH = 10,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/led_brightness_ramp_stepper.sv =====
// Two-channel LED ramp stepper. Items enter on req_ and each yields one result on rsp_
// holding the PWM duties, enables and reached level after that item. An item passes the
// synchronous ramp-table read and then the compare-and-step, each registered; a new item
// is accepted while the last one steps, so one item per cycle is
// sustained while rsp_ready is high. The level used to address the tables is forwarded from
// the step stage. Tables are undefined until written and have no clearing pass.
module led_brightness_ramp_stepper
   import lbrs_pkg::*;
#(
   parameter int unsigned RAMP_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int unsigned AW = $clog2(RAMP_DEPTH);

   logic                  channel_select_ff;
   logic                  fet_present_ff;
   logic [PwmWidth-1:0]   pwm_top_ff;

   logic [PwmWidth-1:0]   main_duty_ff, main_duty_in;
   logic [FetWidth-1:0]   fet_duty_ff, fet_duty_in;
   logic [PwmWidth-1:0]   second_duty_ff, second_duty_in;
   logic [LevelWidth-1:0] level_ff, level_in;
   logic [1:0]            enables_ff, enables_in;

   logic                  ex_valid_ff;
   cmd_type               ex_cmd_ff;
   logic [LevelWidth-1:0] ex_level_ff;
   logic                  ex_down_ff;
   logic                  ex_nop_ff;

   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   logic                  accept;
   logic                  ex_fire;
   logic [LevelWidth-1:0] cur_level;
   logic                  tick_down;
   logic [LevelWidth:0]   tick_next;
   logic                  tick_nop;
   logic [LevelWidth-1:0] pos;
   logic [AW-1:0]         rd_idx;
   logic [LevelWidth-1:0] ex_level_in;
   logic                  wr_ok;
   logic [AW-1:0]         wr_idx;
   logic                  rd_en;
   logic [PwmWidth-1:0]   main_rd, fet_rd, second_rd;
   logic [FetWidth-1:0]   fet_goal;
   logic                  fet_ok;
   cmd_type               req_cmd;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_select_ff <= 1'b0;
         fet_present_ff    <= 1'b1;
         pwm_top_ff        <= 10'd1023;
      end else if (psel && penable && pwrite) begin
         unique case (reg_index_type'(paddr[3:2]))
            REG_CHANNEL_SELECT: channel_select_ff <= pwdata[0];
            REG_FET_PRESENT:    fet_present_ff    <= pwdata[0];
            REG_PWM_TOP:        pwm_top_ff        <= pwdata[PwmWidth-1:0];
            default:            ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(paddr[3:2]))
         REG_CHANNEL_SELECT: prdata = {31'd0, channel_select_ff};
         REG_FET_PRESENT:    prdata = {31'd0, fet_present_ff};
         REG_PWM_TOP:        prdata = {22'd0, pwm_top_ff};
         default:            prdata = 32'd0;
      endcase
   end

   assign ex_fire   = ex_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !reset && (!ex_valid_ff || ex_fire);
   assign accept    = req_valid && req_ready;
   assign req_cmd   = cmd_type'(req_data.cmd);

   always_comb begin
      cur_level = ex_fire ? level_in : level_ff;
      tick_down = req_data.level_value < cur_level;
      tick_next = tick_down ? {1'b0, cur_level} - 1'b1 : {1'b0, cur_level} + 1'b1;
      tick_nop  = (req_data.level_value == cur_level) || (tick_next == '0)
                  || tick_next[LevelWidth];
      if (req_cmd == CMD_TICK) begin
         pos         = tick_next[LevelWidth-1:0] - 1'b1;
         ex_level_in = tick_next[LevelWidth-1:0];
      end else begin
         pos         = req_data.level_value - 1'b1;
         ex_level_in = req_data.level_value;
      end
      if ({1'b0, pos} >= (LevelWidth+1)'(RAMP_DEPTH)) begin
         rd_idx = AW'(RAMP_DEPTH - 1);
      end else begin
         rd_idx = pos[AW-1:0];
      end
      wr_ok  = {1'b0, req_data.entry_index} < (LevelWidth+1)'(RAMP_DEPTH);
      wr_idx = req_data.entry_index[AW-1:0];
      rd_en  = accept && (req_cmd == CMD_SET_LEVEL || req_cmd == CMD_TICK);
   end

   lbrs_ram #(.WIDTH(PwmWidth), .DEPTH(RAMP_DEPTH)) u_main_ram (
      .clock   (clock),
      .wr_en   (accept && req_cmd == CMD_WRITE_ENTRY && wr_ok
                && table_sel_type'(req_data.table_select) == TBL_MAIN),
      .wr_addr (wr_idx),
      .wr_data (req_data.entry_value),
      .rd_en   (rd_en),
      .rd_addr (rd_idx),
      .rd_data (main_rd)
   );

   lbrs_ram #(.WIDTH(PwmWidth), .DEPTH(RAMP_DEPTH)) u_fet_ram (
      .clock   (clock),
      .wr_en   (accept && req_cmd == CMD_WRITE_ENTRY && wr_ok
                && table_sel_type'(req_data.table_select) == TBL_FET),
      .wr_addr (wr_idx),
      .wr_data (req_data.entry_value),
      .rd_en   (rd_en),
      .rd_addr (rd_idx),
      .rd_data (fet_rd)
   );

   lbrs_ram #(.WIDTH(PwmWidth), .DEPTH(RAMP_DEPTH)) u_second_ram (
      .clock   (clock),
      .wr_en   (accept && req_cmd == CMD_WRITE_ENTRY && wr_ok
                && table_sel_type'(req_data.table_select) == TBL_SECOND),
      .wr_addr (wr_idx),
      .wr_data (req_data.entry_value),
      .rd_en   (rd_en),
      .rd_addr (rd_idx),
      .rd_data (second_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff <= 1'b0;
      end else if (req_ready) begin
         ex_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ex_cmd_ff   <= req_cmd;
         ex_level_ff <= ex_level_in;
         ex_down_ff  <= tick_down;
         ex_nop_ff   <= tick_nop;
      end
   end

   always_comb begin
      main_duty_in   = main_duty_ff;
      fet_duty_in    = fet_duty_ff;
      second_duty_in = second_duty_ff;
      level_in       = level_ff;
      enables_in     = enables_ff;
      fet_goal       = fet_rd[FetShift +: FetWidth];
      fet_ok         = 1'b1;
      unique case (ex_cmd_ff)
         CMD_SET_LEVEL: begin
            level_in = ex_level_ff;
            if (ex_level_ff == '0) begin
               main_duty_in   = '0;
               fet_duty_in    = '0;
               second_duty_in = '0;
               enables_in     = 2'b00;
            end else if (!channel_select_ff) begin
               enables_in     = 2'b01;
               main_duty_in   = main_rd;
               fet_duty_in    = fet_present_ff ? fet_goal : '0;
               second_duty_in = '0;
            end else begin
               enables_in     = 2'b10;
               main_duty_in   = '0;
               fet_duty_in    = '0;
               second_duty_in = second_rd;
            end
         end
         CMD_TICK: begin
            if (!ex_nop_ff) begin
               if (!channel_select_ff) begin
                  if (ex_down_ff && main_duty_ff == '0 && main_rd == pwm_top_ff) begin
                     main_duty_in = pwm_top_ff;
                  end else begin
                     main_duty_in = step_toward(main_duty_ff, main_rd);
                  end
                  if (fet_present_ff) begin
                     fet_duty_in = FetWidth'(step_toward(PwmWidth'(fet_duty_ff),
                                                         PwmWidth'(fet_goal)));
                     fet_ok      = fet_duty_in == fet_goal;
                  end else begin
                     fet_duty_in = '0;
                  end
                  if (main_duty_in == main_rd && fet_ok) begin
                     level_in = ex_level_ff;
                  end
               end else begin
                  second_duty_in = step_toward(second_duty_ff, second_rd);
                  if (second_duty_in == second_rd) begin
                     level_in = ex_level_ff;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_duty_ff   <= '0;
         fet_duty_ff    <= '0;
         second_duty_ff <= '0;
         level_ff       <= '0;
         enables_ff     <= '0;
      end else if (ex_fire) begin
         main_duty_ff   <= main_duty_in;
         fet_duty_ff    <= fet_duty_in;
         second_duty_ff <= second_duty_in;
         level_ff       <= level_in;
         enables_ff     <= enables_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ex_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ex_fire) begin
         rsp_data_ff.main_pwm      <= main_duty_in;
         rsp_data_ff.fet_pwm       <= fet_duty_in;
         rsp_data_ff.second_pwm    <= second_duty_in;
         rsp_data_ff.main_enable   <= enables_in[0];
         rsp_data_ff.second_enable <= enables_in[1];
         rsp_data_ff.current_level <= level_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/lbrs_checker.sv =====
module lbrs_checker
   import lbrs_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data,
   input logic    pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Result item changed while stalled.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result item present after reset.");

   a_one_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.main_enable && rsp_data.second_enable))
      else $error("Both channels enabled at once.");

   a_second_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.second_enable |->
         rsp_data.main_pwm == '0 && rsp_data.fet_pwm == '0)
      else $error("Main PWM active while the second channel is enabled.");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> pready)
      else $error("Configuration port not ready.");

endmodule

bind led_brightness_ramp_stepper lbrs_checker u_lbrs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .pready    (pready)
);

// ===== bench/led_brightness_ramp_stepper_tb.sv =====
module led_brightness_ramp_stepper_tb;
   import lbrs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned HOLD_CYCLES    = 120;
   localparam int unsigned HOLD_AFTER     = 40;
   localparam int unsigned PHASE_ITEMS    = 40;
   localparam int unsigned WINDOW         = 8;
   localparam int unsigned PHASES         = 5;

   typedef struct {
      req_type req;
      rsp_type due;
   } ramp_job_type;

   typedef enum int unsigned {
      READY_ALWAYS,
      READY_COIN,
      READY_PATTERN
   } stall_style_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // Predictor state.
   logic [PwmWidth-1:0]   main_tbl [256];
   logic [PwmWidth-1:0]   fet_tbl [256];
   logic [PwmWidth-1:0]   second_tbl [256];
   bit                    loaded [3][256];
   logic [PwmWidth-1:0]   main_duty_q = '0;
   logic [FetWidth-1:0]   fet_duty_q = '0;
   logic [PwmWidth-1:0]   second_duty_q = '0;
   logic [LevelWidth-1:0] level_q = '0;
   logic [1:0]            enables_q = '0;
   logic                  sel_second = 1'b0;
   logic                  fet_fitted = 1'b1;
   logic [PwmWidth-1:0]   turbo_top = 10'd1023;

   ramp_job_type cmd_backlog [$];
   rsp_type     pwm_due [$];
   rsp_type     offered_due;
   bit          req_taken = 1'b0;
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   int unsigned results_seen = 0;
   int unsigned error_count = 0;
   int unsigned quiet_cycles = 0;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;
   int unsigned style_left = 0;
   stall_style_type stall_style = READY_ALWAYS;
   logic [7:0]  stall_mask = '1;

   led_brightness_ramp_stepper u_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [PwmWidth-1:0] nudge(input logic [PwmWidth-1:0] cur,
                                                 input logic [PwmWidth-1:0] goal);
      if (cur < goal) begin
         return cur + 1'b1;
      end else if (cur > goal) begin
         return cur - 1'b1;
      end
      return cur;
   endfunction

   function automatic rsp_type predict_ramp(input req_type r);
      rsp_type               o;
      logic                  down;
      logic [LevelWidth:0]   nxt;
      logic [LevelWidth-1:0] ix;
      logic [PwmWidth-1:0]   goal;
      logic [FetWidth-1:0]   fgoal;
      bit                    fet_ok;
      case (r.cmd)
         CMD_WRITE_ENTRY: begin
            case (r.table_select)
               TBL_MAIN:   main_tbl[r.entry_index] = r.entry_value;
               TBL_FET:    fet_tbl[r.entry_index] = r.entry_value;
               TBL_SECOND: second_tbl[r.entry_index] = r.entry_value;
               default: ;
            endcase
            if (r.table_select != TBL_NONE) begin
               loaded[r.table_select][r.entry_index] = 1'b1;
            end
         end
         CMD_SET_LEVEL: begin
            level_q = r.level_value;
            ix = r.level_value - 1'b1;
            if (r.level_value == '0) begin
               main_duty_q = '0;
               fet_duty_q = '0;
               second_duty_q = '0;
               enables_q = 2'b00;
            end else if (!sel_second) begin
               enables_q = 2'b01;
               main_duty_q = main_tbl[ix];
               fet_duty_q = fet_fitted ? fet_tbl[ix][PwmWidth-1:FetShift] : '0;
               second_duty_q = '0;
            end else begin
               enables_q = 2'b10;
               main_duty_q = '0;
               fet_duty_q = '0;
               second_duty_q = second_tbl[ix];
            end
         end
         CMD_TICK: begin
            if (r.level_value != level_q) begin
               down = r.level_value < level_q;
               nxt = down ? {1'b0, level_q} - 1'b1 : {1'b0, level_q} + 1'b1;
               if (nxt != '0 && !nxt[LevelWidth]) begin
                  ix = nxt[LevelWidth-1:0] - 1'b1;
                  if (!sel_second) begin
                     goal = main_tbl[ix];
                     if (down && main_duty_q == '0 && goal == turbo_top) begin
                        main_duty_q = turbo_top;
                     end else begin
                        main_duty_q = nudge(main_duty_q, goal);
                     end
                     fet_ok = 1'b1;
                     if (fet_fitted) begin
                        fgoal = fet_tbl[ix][PwmWidth-1:FetShift];
                        fet_duty_q = FetWidth'(nudge(PwmWidth'(fet_duty_q),
                                                     PwmWidth'(fgoal)));
                        fet_ok = (fet_duty_q == fgoal);
                     end else begin
                        fet_duty_q = '0;
                     end
                     if (main_duty_q == goal && fet_ok) begin
                        level_q = nxt[LevelWidth-1:0];
                     end
                  end else begin
                     goal = second_tbl[ix];
                     second_duty_q = nudge(second_duty_q, goal);
                     if (second_duty_q == goal) begin
                        level_q = nxt[LevelWidth-1:0];
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      o.main_pwm = main_duty_q;
      o.fet_pwm = fet_duty_q;
      o.second_pwm = second_duty_q;
      o.main_enable = enables_q[0];
      o.second_enable = enables_q[1];
      o.current_level = level_q;
      return o;
   endfunction

   function automatic req_type make_req(input cmd_type c, input table_sel_type s,
                                        input int unsigned ix, input int unsigned v,
                                        input int unsigned lv);
      req_type r;
      r.cmd = c;
      r.table_select = s;
      r.entry_index = 8'(ix);
      r.entry_value = 10'(v);
      r.level_value = 8'(lv);
      return r;
   endfunction

   function automatic void queue_item(input req_type r);
      ramp_job_type j;
      j.req = r;
      j.due = predict_ramp(r);
      cmd_backlog.push_back(j);
   endfunction

   function automatic bit entry_ready(input int unsigned ix);
      return loaded[TBL_MAIN][ix] && loaded[TBL_FET][ix] && loaded[TBL_SECOND][ix];
   endfunction

   function automatic void load_window(input int unsigned w);
      int unsigned k;
      int unsigned roll;
      int unsigned v;
      for (k = w; k < w + WINDOW; k++) begin
         roll = $urandom_range(0, 9);
         v = (roll == 0) ? 32'(turbo_top) : (roll == 1) ? 0 : k * 4 + $urandom_range(0, 3);
         queue_item(make_req(CMD_WRITE_ENTRY, TBL_MAIN, k, v, $urandom_range(0, 255)));
         roll = $urandom_range(0, 9);
         v = (roll == 0) ? 0 : (roll == 1) ? 1023 : k * 2 + $urandom_range(0, 7);
         queue_item(make_req(CMD_WRITE_ENTRY, TBL_FET, k, v, $urandom_range(0, 255)));
         roll = $urandom_range(0, 9);
         v = (roll == 0) ? 1023 : k * 4 + $urandom_range(0, 3);
         queue_item(make_req(CMD_WRITE_ENTRY, TBL_SECOND, k, v, $urandom_range(0, 255)));
      end
   endfunction

   // A tick only ever steps onto a level whose table entries are loaded.
   function automatic void queue_phase(input int unsigned w);
      int unsigned i;
      int unsigned roll;
      int unsigned target;
      int          nxt;
      load_window(w);
      queue_item(make_req(CMD_SET_LEVEL, table_sel_type'($urandom_range(0, 3)),
                          $urandom_range(0, 255), $urandom_range(0, 1023),
                          w + 1 + $urandom_range(0, WINDOW - 1)));
      for (i = 0; i < PHASE_ITEMS; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            queue_item(make_req(CMD_WRITE_ENTRY, table_sel_type'($urandom_range(0, 3)),
                                $urandom_range(0, 255), $urandom_range(0, 1023),
                                $urandom_range(0, 255)));
         end else if (roll < 10) begin
            queue_item(make_req(CMD_NONE, table_sel_type'($urandom_range(0, 3)),
                                $urandom_range(0, 255), $urandom_range(0, 1023),
                                $urandom_range(0, 255)));
         end else if (roll < 20) begin
            target = ($urandom_range(0, 5) == 0) ? 0 : w + 1 + $urandom_range(0, WINDOW - 1);
            queue_item(make_req(CMD_SET_LEVEL, table_sel_type'($urandom_range(0, 3)),
                                $urandom_range(0, 255), $urandom_range(0, 1023), target));
         end else begin
            target = ($urandom_range(0, 9) < 7) ? w + $urandom_range(0, WINDOW + 1)
                                                : $urandom_range(0, 255);
            if (target > 255) begin
               target = 255;
            end
            if (target != level_q) begin
               nxt = (target < level_q) ? int'(level_q) - 1 : int'(level_q) + 1;
               if (nxt >= 1 && nxt <= 255 && !entry_ready(nxt - 1)) begin
                  target = 32'(level_q);
               end
            end
            queue_item(make_req(CMD_TICK, table_sel_type'($urandom_range(0, 3)),
                                $urandom_range(0, 255), $urandom_range(0, 1023), target));
         end
      end
   endfunction

   task automatic flag_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic write_register(input reg_index_type idx, input logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== value) begin
         flag_mismatch("register readback", prdata, value);
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic wait_drained();
      do begin
         @(posedge clock);
         #0.5;
      end while (cmd_backlog.size() != 0 || req_valid || pwm_due.size() != 0);
   endtask

   // Sender: bursts of items separated by random gaps.
   always @(negedge clock) begin
      bit send;
      send = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (cmd_backlog.size() != 0) begin
            send = 1'b1;
            req_data <= cmd_backlog[0].req;
            offered_due = cmd_backlog[0].due;
            void'(cmd_backlog.pop_front());
            if (burst_left > 0) begin
               burst_left--;
            end
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
         req_valid <= send;
      end
   end

   // Receiver: changing stall styles, plus one long hold-off.
   always @(negedge clock) begin
      bit ready_next;
      ready_next = 1'b1;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            if (style_left == 0) begin
               stall_style = stall_style_type'($urandom_range(0, 2));
               style_left = $urandom_range(16, 64);
               stall_mask = 8'($urandom_range(0, 255));
            end
            style_left--;
            case (stall_style)
               READY_COIN:    ready_next = 1'($urandom_range(0, 1));
               READY_PATTERN: ready_next = stall_mask[style_left[2:0]];
               default:       ready_next = 1'b1;
            endcase
         end
         rsp_ready <= ready_next;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            pwm_due.push_back(offered_due);
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (pwm_due.size() == 0) begin
               flag_mismatch("result with nothing pending", 32'(rsp_data.current_level), 0);
            end else begin
               want = pwm_due.pop_front();
               if (rsp_data.main_pwm !== want.main_pwm)
                  flag_mismatch("main_pwm", 32'(rsp_data.main_pwm), 32'(want.main_pwm));
               if (rsp_data.fet_pwm !== want.fet_pwm)
                  flag_mismatch("fet_pwm", 32'(rsp_data.fet_pwm), 32'(want.fet_pwm));
               if (rsp_data.second_pwm !== want.second_pwm)
                  flag_mismatch("second_pwm", 32'(rsp_data.second_pwm),
                                32'(want.second_pwm));
               if (rsp_data.main_enable !== want.main_enable)
                  flag_mismatch("main_enable", 32'(rsp_data.main_enable),
                                32'(want.main_enable));
               if (rsp_data.second_enable !== want.second_enable)
                  flag_mismatch("second_enable", 32'(rsp_data.second_enable),
                                32'(want.second_enable));
               if (rsp_data.current_level !== want.current_level)
                  flag_mismatch("current_level", 32'(rsp_data.current_level),
                                32'(want.current_level));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned chan_set [PHASES];
      int unsigned fet_set [PHASES];
      int unsigned top_set [PHASES];
      int unsigned p;
      int unsigned top;

      chan_set = '{1, 0, 0, 1, 0};
      fet_set  = '{1, 0, 1, 0, 1};
      top_set  = '{1023, 1, 1, 512, 0};

      // Ramp from level 1 to 2, then the turbo bypass on the way down from the top level.
      queue_item(make_req(CMD_WRITE_ENTRY, TBL_MAIN, 0, 0, 255));
      queue_item(make_req(CMD_WRITE_ENTRY, TBL_FET, 0, 0, 0));
      queue_item(make_req(CMD_WRITE_ENTRY, TBL_SECOND, 0, 0, 255));
      queue_item(make_req(CMD_WRITE_ENTRY, TBL_MAIN, 1, 3, 0));
      queue_item(make_req(CMD_WRITE_ENTRY, TBL_FET, 1, 8, 255));
      queue_item(make_req(CMD_WRITE_ENTRY, TBL_SECOND, 1, 2, 0));
      queue_item(make_req(CMD_WRITE_ENTRY, TBL_MAIN, 253, 1023, 0));
      queue_item(make_req(CMD_WRITE_ENTRY, TBL_FET, 253, 1023, 0));
      queue_item(make_req(CMD_WRITE_ENTRY, TBL_SECOND, 253, 1023, 0));
      queue_item(make_req(CMD_WRITE_ENTRY, TBL_MAIN, 254, 0, 0));
      queue_item(make_req(CMD_WRITE_ENTRY, TBL_FET, 254, 1023, 0));
      queue_item(make_req(CMD_WRITE_ENTRY, TBL_SECOND, 254, 1023, 0));
      queue_item(make_req(CMD_WRITE_ENTRY, TBL_MAIN, 255, 1023, 255));
      queue_item(make_req(CMD_WRITE_ENTRY, TBL_NONE, 5, 1023, 0));
      queue_item(make_req(CMD_NONE, TBL_NONE, 255, 1023, 255));
      queue_item(make_req(CMD_SET_LEVEL, TBL_MAIN, 0, 0, 1));
      queue_item(make_req(CMD_TICK, TBL_MAIN, 0, 0, 1));
      queue_item(make_req(CMD_TICK, TBL_MAIN, 0, 0, 0));
      repeat (3) queue_item(make_req(CMD_TICK, TBL_MAIN, 0, 0, 255));
      queue_item(make_req(CMD_SET_LEVEL, TBL_MAIN, 0, 0, 255));
      queue_item(make_req(CMD_TICK, TBL_MAIN, 0, 0, 0));
      queue_item(make_req(CMD_SET_LEVEL, TBL_MAIN, 0, 0, 0));

      queue_phase(0);

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      for (p = 0; p < PHASES; p++) begin
         wait_drained();
         repeat (4) @(posedge clock);
         top = (top_set[p] == 0) ? $urandom_range(2, 1022) : top_set[p];
         write_register(REG_CHANNEL_SELECT, chan_set[p]);
         write_register(REG_FET_PRESENT, fet_set[p]);
         write_register(REG_PWM_TOP, top);
         sel_second = chan_set[p][0];
         fet_fitted = fet_set[p][0];
         turbo_top = PwmWidth'(top);
         queue_phase((p == 0) ? 256 - WINDOW - 1 : $urandom_range(0, 256 - WINDOW - 1));
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
